// ----- hw/rtl/iss_pkg.sv -----
// Shared types and constants for the icon size select scanner.
package iss_pkg;

	localparam int unsigned WORD_W       = 32;
	localparam int unsigned PREF_W       = 11;
	localparam int unsigned OFFSET_W     = 16;
	localparam int unsigned DIM_W        = 11;
	localparam int unsigned MAX_WORDS_DEF = 65536;
	localparam int unsigned MAX_SIDE_DEF  = 1024;
	localparam logic [PREF_W-1:0] PREF_RESET = 11'd26;

	typedef enum logic [1:0] {
		PH_WIDTH,
		PH_HEIGHT,
		PH_PAYLOAD,
		PH_HALT
	} phase_t;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] best_offset;
		logic [DIM_W-1:0]    best_width;
		logic [DIM_W-1:0]    best_height;
	} result_t;

endpackage

// ----- hw/rtl/iss_ifs.sv -----
// Valid/ready channel interfaces for the scanner's word input and result output.
interface iss_word_if import iss_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] word;
	logic              last;

	modport source (output valid, output word, output last, input ready);
	modport sink (input valid, input word, input last, output ready);
endinterface

interface iss_result_if import iss_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                found;
	logic [OFFSET_W-1:0] best_offset;
	logic [DIM_W-1:0]    best_width;
	logic [DIM_W-1:0]    best_height;

	modport source (output valid, output found, output best_offset, output best_width,
		output best_height, input ready);
	modport sink (input valid, input found, input best_offset, input best_width,
		input best_height, output ready);
endinterface

// ----- hw/rtl/iss_scan.sv -----
// Input register and per-word scan state update with entry selection.
module iss_scan import iss_pkg::*; #(
	parameter int unsigned MAX_WORDS = MAX_WORDS_DEF,
	parameter int unsigned MAX_SIDE  = MAX_SIDE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [PREF_W-1:0] preferred_side,
	input  logic              in_valid,
	input  logic [WORD_W-1:0] in_word,
	input  logic              in_last,
	output logic              in_ready,
	input  logic              res_free,
	output logic              res_valid,
	output result_t           res
);

	localparam int unsigned POS_W  = $clog2(MAX_WORDS + 1);
	localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int unsigned PAY_W  = 2 * SIDE_W;
	localparam int unsigned CMP_W  = (SIDE_W > PREF_W) ? SIDE_W : PREF_W;

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              last_s1;
	logic              adv;

	phase_t              phase_q, phase_d;
	logic [POS_W-1:0]    pos_q;
	logic [OFFSET_W-1:0] estart_q;
	logic [SIDE_W-1:0]   ew_q, eh_q;
	logic [PAY_W-1:0]    pay_q;
	logic                have_q;
	logic [OFFSET_W-1:0] bstart_q;
	logic [SIDE_W-1:0]   bw_q, bh_q, bside_q;

	logic                pos_full, active, side_ok, pay_done, better, weigh;
	logic [PAY_W-1:0]    pay_dec, pay_prod;
	logic [SIDE_W-1:0]   side;
	logic [CMP_W-1:0]    side_c, bside_c, pref_c;
	logic                have_d;
	logic [OFFSET_W-1:0] bstart_d;
	logic [SIDE_W-1:0]   bw_d, bh_d;

	// A word marked last waits in the input register until the result register is free.
	assign adv      = valid_s1 && !(last_s1 && !res_free);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
			last_s1 <= in_last;
		end
	end

	assign pos_full = pos_q >= POS_W'(MAX_WORDS);
	assign active   = (phase_q != PH_HALT) && !pos_full;
	assign side_ok  = (word_s1 >= WORD_W'(1)) && (word_s1 <= WORD_W'(MAX_SIDE));
	assign pay_dec  = (pay_q == '0) ? '0 : pay_q - PAY_W'(1);
	assign pay_done = pay_dec == '0;
	assign pay_prod = PAY_W'(ew_q) * PAY_W'(word_s1[SIDE_W-1:0]);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (phase_q != PH_HALT) begin
			if (pos_full) begin
				phase_d = PH_HALT;
			end else begin
				case (phase_q)
					PH_WIDTH:   phase_d = side_ok ? PH_HEIGHT : PH_HALT;
					PH_HEIGHT:  phase_d = side_ok ? PH_PAYLOAD : PH_HALT;
					PH_PAYLOAD: phase_d = pay_done ? PH_WIDTH : PH_PAYLOAD;
					default:    phase_d = PH_HALT;
				endcase
			end
		end
	end

	// Selection of the kept entry and the result it gives.
	always_comb begin
		side    = (ew_q < eh_q) ? ew_q : eh_q;
		side_c  = CMP_W'(side);
		bside_c = CMP_W'(bside_q);
		pref_c  = CMP_W'(preferred_side);
		better  = !have_q
			|| ((bside_c < pref_c) && (side_c > bside_c))
			|| ((side_c >= pref_c) && ((bside_c < pref_c) || (side_c < bside_c)));
		weigh    = active && (phase_q == PH_PAYLOAD) && pay_done && better;
		have_d   = have_q || weigh;
		bstart_d = weigh ? estart_q : bstart_q;
		bw_d     = weigh ? ew_q : bw_q;
		bh_d     = weigh ? eh_q : bh_q;

		res_valid       = adv && last_s1;
		res.found       = have_d;
		res.best_offset = have_d ? bstart_d : '0;
		res.best_width  = have_d ? DIM_W'(bw_d) : '0;
		res.best_height = have_d ? DIM_W'(bh_d) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WIDTH;
			pos_q   <= '0;
			have_q  <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				phase_q <= PH_WIDTH;
				pos_q   <= '0;
				have_q  <= 1'b0;
			end else begin
				phase_q <= phase_d;
				pos_q   <= active ? pos_q + POS_W'(1) : pos_q;
				have_q  <= have_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && active) begin
			if (phase_q == PH_WIDTH && side_ok) begin
				estart_q <= OFFSET_W'(pos_q);
				ew_q     <= word_s1[SIDE_W-1:0];
			end
			if (phase_q == PH_HEIGHT && side_ok) begin
				eh_q  <= word_s1[SIDE_W-1:0];
				pay_q <= pay_prod;
			end
			if (phase_q == PH_PAYLOAD) begin
				pay_q <= pay_dec;
			end
			if (weigh) begin
				bstart_q <= estart_q;
				bw_q     <= ew_q;
				bh_q     <= eh_q;
				bside_q  <= side;
			end
		end
	end

endmodule

// ----- hw/rtl/iss_out_reg.sv -----
// Output register holding one result until the downstream transfer.
module iss_out_reg import iss_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t load_res,
	output logic    free,
	iss_result_if.source result
);

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end
	end

	assign result.valid       = valid_q;
	assign result.found       = res_q.found;
	assign result.best_offset = res_q.best_offset;
	assign result.best_width  = res_q.best_width;
	assign result.best_height = res_q.best_height;

endmodule

// ----- hw/rtl/icon_size_select_scanner_top.sv -----
// Top level of the icon size select scanner.
// The scanner takes one icon array word per cycle and keeps up with back-to-back
// transfers. Each word is captured in an input register, and as it leaves that
// register the scan state (entry phase, word position, payload count, kept entry)
// is updated in one pass; the width-times-height payload count and the size compare
// sit in that combinational update. The result for an array is loaded into the
// output register at the edge at which its last word leaves the input register, and
// the scan state is already clear for the next array. While a result waits in the
// output register, the next array's last word holds in the input register and stalls
// the word input.
// preferred_side may be written only while no array is in flight.
module icon_size_select_scanner_top import iss_pkg::*; #(
	parameter int unsigned MAX_WORDS = MAX_WORDS_DEF,
	parameter int unsigned MAX_SIDE  = MAX_SIDE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [PREF_W-1:0] cfg_wr_data,
	iss_word_if.sink          words,
	iss_result_if.source      result
);

	logic [PREF_W-1:0] pref_q;
	logic              res_free;
	logic              res_valid;
	result_t           res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pref_q <= PREF_RESET;
		end else if (cfg_wr_en) begin
			pref_q <= cfg_wr_data;
		end
	end

	iss_scan #(
		.MAX_WORDS (MAX_WORDS),
		.MAX_SIDE  (MAX_SIDE)
	) u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.preferred_side (pref_q),
		.in_valid       (words.valid),
		.in_word        (words.word),
		.in_last        (words.last),
		.in_ready       (words.ready),
		.res_free       (res_free),
		.res_valid      (res_valid),
		.res            (res)
	);

	iss_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.load_res (res),
		.free     (res_free),
		.result   (result)
	);

endmodule

// ----- tb/sv/icon_size_select_scanner_checker.sv -----
// Scoreboard for the icon size select scanner: tracks the scan, predicts each result, compares.
`timescale 1ns / 1ps
module icon_size_select_scanner_checker import iss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [PREF_W-1:0] cfg_wr_data,
	iss_word_if               words,
	iss_result_if             result,
	output int                mismatches,
	output int                awaited
);

	logic [PREF_W-1:0]   pref_side;
	phase_t              scan_phase;
	logic [16:0]         word_pos;
	logic [OFFSET_W-1:0] cur_start;
	logic [DIM_W-1:0]    cur_w;
	logic [DIM_W-1:0]    cur_h;
	logic [20:0]         pixels_left;
	logic                kept_valid;
	logic [OFFSET_W-1:0] kept_start;
	logic [DIM_W-1:0]    kept_w;
	logic [DIM_W-1:0]    kept_h;
	logic [DIM_W-1:0]    kept_side;
	result_t             expected_results[$];
	result_t             want;
	result_t             choice;

	task automatic clear_scan();
		scan_phase = PH_WIDTH;
		word_pos = '0;
		cur_start = '0;
		cur_w = '0;
		cur_h = '0;
		pixels_left = '0;
		kept_valid = 1'b0;
		kept_start = '0;
		kept_w = '0;
		kept_h = '0;
		kept_side = '0;
	endtask

	// Advances the scan by one array word.
	task automatic absorb_word(input logic [WORD_W-1:0] w);
		logic             side_fits;
		logic [DIM_W-1:0] side;
		side_fits = (w >= 1) && (w <= MAX_SIDE_DEF);
		if (scan_phase == PH_HALT)
			return;
		if (word_pos >= MAX_WORDS_DEF) begin
			scan_phase = PH_HALT;
			return;
		end
		case (scan_phase)
			PH_WIDTH: begin
				if (side_fits) begin
					cur_start = word_pos[OFFSET_W-1:0];
					cur_w = w[DIM_W-1:0];
					scan_phase = PH_HEIGHT;
				end else begin
					scan_phase = PH_HALT;
				end
			end
			PH_HEIGHT: begin
				if (side_fits) begin
					cur_h = w[DIM_W-1:0];
					pixels_left = cur_w * cur_h;
					scan_phase = PH_PAYLOAD;
				end else begin
					scan_phase = PH_HALT;
				end
			end
			default: begin
				if (pixels_left != 0)
					pixels_left = pixels_left - 1'b1;
				if (pixels_left == 0) begin
					// The entry is complete; weigh its smaller side against the kept one.
					side = (cur_w < cur_h) ? cur_w : cur_h;
					if (!kept_valid
							|| (kept_side < pref_side && side > kept_side)
							|| (side >= pref_side && (kept_side < pref_side || side < kept_side))) begin
						kept_valid = 1'b1;
						kept_start = cur_start;
						kept_w = cur_w;
						kept_h = cur_h;
						kept_side = side;
					end
					scan_phase = PH_WIDTH;
				end
			end
		endcase
		word_pos = word_pos + 1'b1;
	endtask

	task automatic check_field(input string field, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val,
				act_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			pref_side = PREF_RESET;
			expected_results.delete();
			mismatches = 0;
		end else begin
			if (cfg_wr_en)
				pref_side = cfg_wr_data;
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual found %0d offset %0d %0dx%0d",
						$time, result.found, result.best_offset, result.best_width,
						result.best_height);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("found", want.found, result.found);
					check_field("best_offset", want.best_offset, result.best_offset);
					check_field("best_width", want.best_width, result.best_width);
					check_field("best_height", want.best_height, result.best_height);
				end
			end
			if (words.valid && words.ready) begin
				absorb_word(words.word);
				if (words.last) begin
					choice = '0;
					if (kept_valid) begin
						choice.found = 1'b1;
						choice.best_offset = kept_start;
						choice.best_width = kept_w;
						choice.best_height = kept_h;
					end
					expected_results.push_back(choice);
					clear_scan();
				end
			end
		end
		awaited = expected_results.size();
	end

endmodule

// ----- tb/sv/icon_size_select_scanner_top_tb.sv -----
// Testbench top for the icon size select scanner: clock, reset, icon array stimulus, verdict.
`timescale 1ns / 1ps
module icon_size_select_scanner_top_tb;
	import iss_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_WORDS = 120;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en;
	logic [PREF_W-1:0] cfg_wr_data;
	logic              quiet = 1'b0;
	int                holds_asked = 0;
	int                holds_served;
	int                mismatches;
	int                awaited;
	int                words_sent = 0;
	int                cycle_count = 0;
	logic [WORD_W-1:0] array_words[$];

	iss_word_if   words_if();
	iss_result_if result_if();

	icon_size_select_scanner_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.words      (words_if),
		.result     (result_if)
	);

	icon_size_select_scanner_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.words      (words_if),
		.result     (result_if),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Called at a falling edge; returns at the falling edge after the transfer with valid
	// still high, so a following word keeps the channel busy without a gap.
	task automatic send_word(input logic [WORD_W-1:0] w, input logic l);
		while (!quiet && $urandom_range(99) < 8) begin
			words_if.valid <= 1'b0;
			@(negedge clk);
		end
		words_if.valid <= 1'b1;
		words_if.word <= w;
		words_if.last <= l;
		@(posedge clk);
		while (!words_if.ready)
			@(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_array();
		int n;
		n = array_words.size();
		for (int i = 0; i < n; i++)
			send_word(array_words[i], i == n - 1);
		array_words.delete();
	endtask

	task automatic add_entry(input int unsigned w, input int unsigned h);
		array_words.push_back(w);
		array_words.push_back(h);
		repeat (w * h)
			array_words.push_back($urandom);
	endtask

	function automatic int unsigned pick_side();
		if ($urandom_range(99) < 85)
			return $urandom_range(1, 6);
		return $urandom_range(7, 12);
	endfunction

	function automatic logic [WORD_W-1:0] bad_side();
		logic [WORD_W-1:0] v;
		v = $urandom;
		case ($urandom_range(2))
			0: v = 0;
			1: v = MAX_SIDE_DEF + 1;
			default: begin
				if (v >= 1 && v <= MAX_SIDE_DEF)
					v = 0;
			end
		endcase
		return v;
	endfunction

	// Mostly well-formed arrays; some end in a cut entry, a lone width, a bad side or noise.
	task automatic build_random_array();
		int unsigned w;
		int unsigned h;
		w = 1;
		h = 1;
		repeat ($urandom_range(1, 4)) begin
			w = pick_side();
			h = pick_side();
			add_entry(w, h);
		end
		case ($urandom_range(9))
			6: repeat ($urandom_range(1, w * h + 1))
				void'(array_words.pop_back());
			7: array_words.push_back(pick_side());
			8: begin
				if ($urandom_range(1) == 0) begin
					array_words.push_back(bad_side());
				end else begin
					array_words.push_back(pick_side());
					array_words.push_back(bad_side());
				end
				repeat ($urandom_range(3))
					array_words.push_back($urandom);
			end
			9: repeat ($urandom_range(1, 4))
				array_words.push_back($urandom);
			default: ;
		endcase
	endtask

	// Drops valid and waits until every result is in and the pipeline has drained.
	task automatic settle();
		words_if.valid <= 1'b0;
		@(negedge clk);
		while (awaited != 0)
			@(negedge clk);
		repeat (4)
			@(negedge clk);
	endtask

	task automatic set_pref(input logic [PREF_W-1:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_phase(input logic [PREF_W-1:0] pref, input logic calm);
		int start;
		set_pref(pref);
		quiet <= calm;
		start = words_sent;
		while (words_sent - start < PHASE_WORDS) begin
			build_random_array();
			send_array();
		end
	endtask

	// Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
	initial begin
		result_if.ready = 1'b0;
		holds_served = 0;
		forever begin
			@(negedge clk);
			if (holds_served != holds_asked) begin
				holds_served++;
				repeat (HOLD_CYCLES) begin
					result_if.ready <= 1'b0;
					@(negedge clk);
				end
			end
			result_if.ready <= quiet || ($urandom_range(99) >= 8);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		words_if.valid = 1'b0;
		words_if.word = '0;
		words_if.last = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed arrays at the reset preferred side.
		array_words.push_back('1);
		send_array();
		array_words.push_back('0);
		send_array();
		add_entry(1, 1);
		send_array();
		array_words = '{3, MAX_SIDE_DEF + 1, 0};
		send_array();
		add_entry(1, 1);
		array_words.push_back(2);
		array_words.push_back(3);
		array_words.push_back($urandom);
		array_words.push_back($urandom);
		send_array();
		add_entry(1, 2);
		array_words.push_back(5);
		send_array();
		add_entry(1, 1);
		add_entry(1, 3);
		send_array();

		// Stall the result side so the block backs up into its input.
		settle();
		holds_asked <= holds_asked + 1;
		repeat (16) begin
			add_entry(1, $urandom_range(1, 2));
			send_array();
		end

		// Largest sides.
		set_pref(1);
		add_entry(2, 1);
		array_words.push_back(MAX_SIDE_DEF);
		array_words.push_back(1);
		array_words.push_back($urandom);
		send_array();
		array_words = '{MAX_SIDE_DEF, MAX_SIDE_DEF, $urandom, $urandom};
		send_array();
		array_words = '{MAX_SIDE_DEF, MAX_SIDE_DEF + 1};
		send_array();
		array_words.push_back(MAX_SIDE_DEF + 1);
		send_array();

		random_phase(3, 1'b0);
		random_phase(0, 1'b0);
		random_phase(2047, 1'b0);
		random_phase(MAX_SIDE_DEF, 1'b0);
		random_phase(PREF_W'($urandom_range(1, 12)), 1'b0);
		random_phase(6, 1'b1);

		settle();
		repeat (8)
			@(negedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
